/* sv/b32c_pkg.sv */
// b32c_pkg: shared types and constants for the base32 codec
// no dependencies; used by every other file of the block except b32c_if
`default_nettype none

package b32c_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int MAX_RESULTS = 3;
    localparam int COUNT_W     = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA0    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA1    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA2    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA3    = 3'd4;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // character k of the alphabet is entry k
    typedef logic [31:0][7:0] alpha_t;

    typedef struct packed {
        logic [7:0] value;
        logic       valid;
        logic       error;
        logic       last;
    } result_t;

    typedef result_t [MAX_RESULTS-1:0] result_set_t;

    typedef struct packed {
        logic [11:0] store;
        logic [2:0]  held;
        logic        discarding;
    } msg_state_t;

endpackage

`default_nettype wire

/* sv/b32c_if.sv */
// b32c_in_if / b32c_out_if: valid-ready channels of the base32 codec
// payload fields follow the item layout; no dependencies
`default_nettype none

interface b32c_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_value;
    logic       in_last;

    modport source (output valid, output in_value, output in_last, input ready);
    modport sink   (input valid, input in_value, input in_last, output ready);
endinterface

interface b32c_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_value;
    logic       out_valid;
    logic       out_error;
    logic       out_last;

    modport source (output valid, output out_value, output out_valid,
                    output out_error, output out_last, input ready);
    modport sink   (input valid, input out_value, input out_valid,
                    input out_error, input out_last, output ready);
endinterface

`default_nettype wire

/* sv/b32c_cfg.sv */
// b32c_cfg: configuration registers (direction, four alphabet words)
// depends on b32c_pkg
`default_nettype none

module b32c_cfg
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             write_enable,
    input  wire logic [b32c_pkg::CFG_INDEX_W-1:0] write_index,
    input  wire logic [b32c_pkg::CFG_DATA_W-1:0]  write_data,
    output logic                                  direction,
    output b32c_pkg::alpha_t                      alphabet,
    output logic                                  dir_write
);

    logic                  direction_reg;
    logic [3:0][63:0]      words_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= b32c_pkg::DIR_ENCODE;
            words_reg     <= '0;
        end
        else if (write_enable)
        begin
            case (write_index)
                b32c_pkg::REG_DIRECTION: direction_reg <= write_data[0];
                b32c_pkg::REG_ALPHA0:    words_reg[0]  <= write_data;
                b32c_pkg::REG_ALPHA1:    words_reg[1]  <= write_data;
                b32c_pkg::REG_ALPHA2:    words_reg[2]  <= write_data;
                b32c_pkg::REG_ALPHA3:    words_reg[3]  <= write_data;
                default: ;
            endcase
        end
    end

    assign direction = direction_reg;
    assign alphabet  = b32c_pkg::alpha_t'(words_reg);
    assign dir_write = write_enable && (write_index == b32c_pkg::REG_DIRECTION);

endmodule

`default_nettype wire

/* sv/b32c_step.sv */
// b32c_step: results and next message state for one item
// depends on b32c_pkg
`default_nettype none

module b32c_step
(
    input  wire logic                   direction,
    input  wire b32c_pkg::alpha_t       alphabet,
    input  wire b32c_pkg::msg_state_t   state,
    input  wire logic [7:0]             value,
    input  wire logic                   last,
    output b32c_pkg::result_set_t       results,
    output logic [b32c_pkg::COUNT_W-1:0] count,
    output b32c_pkg::msg_state_t        state_next
);

    always_comb
    begin
        logic [11:0] ebuf;
        logic [11:0] dbuf;
        logic [11:0] tmp;
        logic [3:0]  ecnt;
        logic [3:0]  er1;
        logic [3:0]  rem;
        logic [3:0]  dcnt;
        logic [4:0]  idx;
        logic [4:0]  val;
        logic        found;
        logic [b32c_pkg::COUNT_W-1:0] n;

        results    = '0;
        n          = '0;
        state_next = state;
        ebuf       = '0;
        dbuf       = '0;
        tmp        = '0;
        ecnt       = '0;
        er1        = '0;
        rem        = '0;
        dcnt       = '0;
        idx        = '0;
        val        = '0;
        found      = 1'b0;

        if (direction == b32c_pkg::DIR_ENCODE)
        begin
            ebuf = {state.store[3:0], value};
            ecnt = {1'b0, state.held} + 4'd8;
            if (ecnt > 4'd12)
                ecnt = 4'd12;
            // first full group
            tmp = ebuf >> (ecnt - 4'd5);
            idx = tmp[4:0];
            er1 = ecnt - 4'd5;
            results[0] = '{alphabet[idx], 1'b1, 1'b0, last && (er1 == 4'd0)};
            n   = 2'd1;
            rem = er1;
            // second full group
            if (er1 >= 4'd5)
            begin
                tmp = ebuf >> (er1 - 4'd5);
                idx = tmp[4:0];
                rem = er1 - 4'd5;
                results[1] = '{alphabet[idx], 1'b1, 1'b0, last && (rem == 4'd0)};
                n   = 2'd2;
            end
            if (last)
            begin
                // zero-filled tail character
                if (rem != 4'd0)
                begin
                    tmp = ebuf << (4'd5 - rem);
                    idx = tmp[4:0];
                    results[n] = '{alphabet[idx], 1'b1, 1'b0, 1'b1};
                    n = n + 2'd1;
                end
                state_next = '0;
            end
            else
            begin
                state_next.store      = ebuf & ((12'd1 << rem) - 12'd1);
                state_next.held       = rem[2:0];
                state_next.discarding = 1'b0;
            end
        end
        else if (state.discarding)
        begin
            if (last)
            begin
                results[0] = '{8'd0, 1'b0, 1'b1, 1'b1};
                n          = 2'd1;
                state_next = '0;
            end
        end
        else
        begin
            // lowest matching index wins; nul never matches
            for (int k = 31; k >= 0; k--)
            begin
                if ((alphabet[k] == value) && (value != 8'd0))
                begin
                    found = 1'b1;
                    val   = 5'(k);
                end
            end
            if (!found)
            begin
                results[0]            = '{8'd0, 1'b0, 1'b1, last};
                n                     = 2'd1;
                state_next.store      = '0;
                state_next.held       = '0;
                state_next.discarding = !last;
            end
            else
            begin
                dbuf = {state.store[6:0], val};
                dcnt = {1'b0, state.held} + 4'd5;
                rem  = dcnt;
                if (dcnt >= 4'd8)
                begin
                    tmp        = dbuf >> (dcnt - 4'd8);
                    results[0] = '{tmp[7:0], 1'b1, 1'b0, last};
                    n          = 2'd1;
                    rem        = dcnt - 4'd8;
                end
                else if (last)
                begin
                    results[0] = '{8'd0, 1'b0, 1'b0, 1'b1};
                    n          = 2'd1;
                end
                if (last)
                    state_next = '0;
                else
                begin
                    state_next.store      = dbuf & ((12'd1 << rem) - 12'd1);
                    state_next.held       = rem[2:0];
                    state_next.discarding = 1'b0;
                end
            end
        end

        count = n;
    end

endmodule

`default_nettype wire

/* sv/b32c_outbuf.sv */
// b32c_outbuf: result register holding up to three results of one item
// depends on b32c_pkg; drains one result per cycle while out_ready is high
`default_nettype none

module b32c_outbuf
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire logic [b32c_pkg::COUNT_W-1:0]  load_count,
    input  wire b32c_pkg::result_set_t         load_results,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output b32c_pkg::result_t                  out_item,
    output logic                               can_load
);

    b32c_pkg::result_set_t          items_reg;
    logic [b32c_pkg::COUNT_W-1:0]   remain_reg;
    logic [b32c_pkg::COUNT_W-1:0]   remain_next;
    logic [b32c_pkg::COUNT_W-1:0]   ptr_reg;
    logic [b32c_pkg::COUNT_W-1:0]   ptr_next;
    logic                           fire;

    assign out_valid = (remain_reg != '0);
    assign fire      = out_valid && out_ready;
    assign can_load  = (remain_reg == '0) || ((remain_reg == 2'd1) && out_ready);

    always_comb
    begin
        remain_next = remain_reg;
        ptr_next    = ptr_reg;
        if (load)
        begin
            remain_next = load_count;
            ptr_next    = '0;
        end
        else if (fire)
        begin
            remain_next = remain_reg - 2'd1;
            ptr_next    = ptr_reg + 2'd1;
        end
    end

    always_comb
    begin
        case (ptr_reg)
            2'd0:    out_item = items_reg[0];
            2'd1:    out_item = items_reg[1];
            2'd2:    out_item = items_reg[2];
            default: out_item = items_reg[0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
            ptr_reg    <= '0;
        end
        else
        begin
            remain_reg <= remain_next;
            ptr_reg    <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            items_reg <= load_results;
    end

endmodule

`default_nettype wire

/* sv/base32_codec_unit.sv */
// base32_codec_unit: top level of the base32 codec without padding
// depends on b32c_pkg, b32c_if, b32c_cfg, b32c_step, b32c_outbuf
//
// An item is taken into the message state and its results (up to three) are written in
// the same cycle into a result register, which hands them out one per cycle while the
// receiver is ready; the next item is taken while the last of those results leaves. An
// item yields one or two characters per byte when encoding (8/5 on average over a long
// message, three for a final byte that closes with a tail character) and at most one
// byte per character when decoding. The result register drain sets the pace.
// The user must write configuration only while no results are pending; the block itself
// does not enforce it. A direction write also clears the message state.
`default_nettype none

module base32_codec_unit
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    b32c_in_if.sink                               request,
    b32c_out_if.source                            result,
    input  wire logic                             write_enable,
    input  wire logic [b32c_pkg::CFG_INDEX_W-1:0] write_index,
    input  wire logic [b32c_pkg::CFG_DATA_W-1:0]  write_data
);

    logic                           direction;
    b32c_pkg::alpha_t               alphabet;
    logic                           dir_write;
    b32c_pkg::msg_state_t           state_reg;
    b32c_pkg::msg_state_t           state_next;
    b32c_pkg::result_set_t          step_results;
    logic [b32c_pkg::COUNT_W-1:0]   step_count;
    logic                           can_load;
    logic                           accept;
    b32c_pkg::result_t              out_item;

    b32c_cfg u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .direction    (direction),
        .alphabet     (alphabet),
        .dir_write    (dir_write)
    );

    b32c_step u_step
    (
        .direction  (direction),
        .alphabet   (alphabet),
        .state      (state_reg),
        .value      (request.in_value),
        .last       (request.in_last),
        .results    (step_results),
        .count      (step_count),
        .state_next (state_next)
    );

    assign request.ready = can_load;
    assign accept        = request.valid && can_load;

    // message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (dir_write)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

    b32c_outbuf u_outbuf
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .load_count   (step_count),
        .load_results (step_results),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .out_item     (out_item),
        .can_load     (can_load)
    );

    assign result.out_value = out_item.value;
    assign result.out_valid = out_item.valid;
    assign result.out_error = out_item.error;
    assign result.out_last  = out_item.last;

endmodule

`default_nettype wire

/* sim/tb_base32_codec_unit.sv */
// tb_base32_codec_unit: self-checking testbench for the base32 codec without padding
// depends on b32c_pkg, b32c_if and base32_codec_unit; predicts every result item itself
// and checks it against the output channel under random sender gaps and receiver stalls
`default_nettype none

module tb_base32_codec_unit;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 20;
    localparam int PHASE_COUNT    = 12;

    typedef enum int {RX_OPEN, RX_PATCHY, RX_CHOKED} rx_mode_t;

    logic                             clk;
    logic                             rst_n;
    logic                             write_enable;
    logic [b32c_pkg::CFG_INDEX_W-1:0] write_index;
    logic [b32c_pkg::CFG_DATA_W-1:0]  write_data;

    b32c_in_if  req_if ();
    b32c_out_if res_if ();

    base32_codec_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (req_if),
        .result       (res_if),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data)
    );

    // predictor state
    logic         m_dir;
    logic [255:0] m_alpha;
    logic [11:0]  m_store;
    logic [2:0]   m_held;
    logic         m_discard;

    b32c_pkg::result_t pending_out[$];
    int                fails = 0;
    int                burst_left;
    int                quiet_cycles = 0;
    rx_mode_t          rx_mode = RX_OPEN;
    int                rx_left = 0;
    int                rx_low_run = 0;
    bit                take;
    b32c_pkg::result_t got;
    b32c_pkg::result_t want;
    logic [255:0]      std_alpha;
    logic [255:0]      hex_alpha;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [255:0] alpha_from_text(string s);
        logic [255:0] a;
        a = '0;
        for (int k = 0; k < 32; k++)
            a[8*k +: 8] = s[k];
        return a;
    endfunction

    function automatic logic [255:0] random_alphabet(bit distinct);
        logic [255:0] a;
        logic [7:0]   c;
        bit           used [256];
        a = '0;
        for (int k = 0; k < 32; k++)
        begin
            if (distinct)
            begin
                do
                    c = 8'($urandom_range(1, 255));
                while (used[c]);
                used[c] = 1'b1;
            end
            else
                c = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(8'h61, 8'h66));
            a[8*k +: 8] = c;
        end
        return a;
    endfunction

    function automatic logic [7:0] alpha_char(logic [4:0] k);
        return m_alpha[8*k +: 8];
    endfunction

    function automatic void push_result(logic [7:0] v, logic valid, logic error, logic last);
        b32c_pkg::result_t r;
        r.value = v;
        r.valid = valid;
        r.error = error;
        r.last  = last;
        pending_out.push_back(r);
    endfunction

    function automatic void clear_message();
        m_store   = '0;
        m_held    = '0;
        m_discard = 1'b0;
    endfunction

    function automatic void reset_model();
        m_dir   = b32c_pkg::DIR_ENCODE;
        m_alpha = '0;
        clear_message();
    endfunction

    function automatic void apply_reg(logic [b32c_pkg::CFG_INDEX_W-1:0] idx,
                                      logic [b32c_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            b32c_pkg::REG_DIRECTION:
            begin
                m_dir = data[0];
                clear_message();
            end
            b32c_pkg::REG_ALPHA0: m_alpha[0 +: 64]   = data;
            b32c_pkg::REG_ALPHA1: m_alpha[64 +: 64]  = data;
            b32c_pkg::REG_ALPHA2: m_alpha[128 +: 64] = data;
            b32c_pkg::REG_ALPHA3: m_alpha[192 +: 64] = data;
            default: ;
        endcase
    endfunction

    // expected results of one accepted item
    function automatic void transcode_item(logic [7:0] v, logic last);
        logic [11:0] bits;
        logic [4:0]  idx;
        logic [4:0]  val;
        int          cnt;
        bit          found;
        if (m_dir == b32c_pkg::DIR_ENCODE)
        begin
            bits = {m_store[3:0], v};
            cnt  = int'(m_held) + 8;
            if (cnt > 12)
                cnt = 12;
            while (cnt >= 5)
            begin
                idx = 5'((bits >> (cnt - 5)) & 12'h01F);
                cnt -= 5;
                push_result(alpha_char(idx), 1'b1, 1'b0, last && (cnt == 0));
            end
            if (last)
            begin
                if (cnt > 0)
                begin
                    idx = 5'((bits << (5 - cnt)) & 12'h01F);
                    push_result(alpha_char(idx), 1'b1, 1'b0, 1'b1);
                end
                clear_message();
            end
            else
            begin
                m_store = bits & ((12'd1 << cnt) - 12'd1);
                m_held  = 3'(cnt);
            end
        end
        else if (m_discard)
        begin
            if (last)
            begin
                push_result(8'h00, 1'b0, 1'b1, 1'b1);
                clear_message();
            end
        end
        else
        begin
            found = 1'b0;
            val   = '0;
            if (v != 8'h00)
                for (int k = 0; k < 32 && !found; k++)
                    if (alpha_char(5'(k)) == v)
                    begin
                        val   = 5'(k);
                        found = 1'b1;
                    end
            if (!found)
            begin
                push_result(8'h00, 1'b0, 1'b1, last);
                if (last)
                    clear_message();
                else
                begin
                    m_store   = '0;
                    m_held    = '0;
                    m_discard = 1'b1;
                end
            end
            else
            begin
                bits = {m_store[6:0], val};
                cnt  = int'(m_held) + 5;
                if (cnt >= 8)
                begin
                    push_result(8'((bits >> (cnt - 8)) & 12'h0FF), 1'b1, 1'b0, last);
                    cnt -= 8;
                end
                else if (last)
                    push_result(8'h00, 1'b0, 1'b0, 1'b1);
                if (last)
                    clear_message();
                else
                begin
                    m_store = bits & ((12'd1 << cnt) - 12'd1);
                    m_held  = 3'(cnt);
                end
            end
        end
    endfunction

    function automatic logic [7:0] pick_char();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 16)
            return alpha_char(5'($urandom_range(0, 31)));
        else if (roll == 16)
            return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic write_reg(input logic [b32c_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [b32c_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        write_enable <= 1'b1;
        write_index  <= idx;
        write_data   <= data;
        @(posedge clk);
        write_enable <= 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic set_config(input logic dir, input logic [255:0] alpha);
        write_reg(b32c_pkg::REG_ALPHA0, alpha[0 +: 64]);
        write_reg(b32c_pkg::REG_ALPHA1, alpha[64 +: 64]);
        write_reg(b32c_pkg::REG_ALPHA2, alpha[128 +: 64]);
        write_reg(b32c_pkg::REG_ALPHA3, alpha[192 +: 64]);
        write_reg(b32c_pkg::REG_DIRECTION, b32c_pkg::CFG_DATA_W'(dir));
    endtask

    // sender idles until every expected item has come out
    task automatic settle();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_item(input logic [7:0] v, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_if.valid    <= 1'b1;
        req_if.in_value <= v;
        req_if.in_last  <= last;
        do
            @(posedge clk);
        while (!req_if.ready);
        transcode_item(v, last);
    endtask

    task automatic random_message(input int len, input bit close);
        logic [7:0] v;
        for (int i = 0; i < len; i++)
        begin
            v = (m_dir == b32c_pkg::DIR_DECODE) ? pick_char() : 8'($urandom_range(0, 255));
            send_item(v, close && (i == len - 1));
        end
    endtask

    task automatic test_encode_basics();
        settle();
        set_config(b32c_pkg::DIR_ENCODE, std_alpha);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'hA5, 1'b0);
        send_item(8'h5A, 1'b0);
        send_item(8'hC3, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h01, 1'b0);
        send_item(8'h02, 1'b0);
        send_item(8'h03, 1'b0);
        send_item(8'h04, 1'b0);
        send_item(8'h80, 1'b1);
    endtask

    task automatic test_decode_basics();
        settle();
        set_config(b32c_pkg::DIR_DECODE, std_alpha);
        // highest index twice, one full byte on the last item
        send_item("7", 1'b0);
        send_item("7", 1'b1);
        // last item with no byte
        send_item("A", 1'b1);
        // a known character, an unknown one, then the rest of the message is dropped
        send_item("M", 1'b0);
        send_item("x", 1'b0);
        send_item("A", 1'b0);
        send_item("A", 1'b1);
        // nul never matches
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_alphabet_corners();
        logic [255:0] a;
        a = std_alpha;
        a[7:0]   = 8'h00;
        a[15:8]  = "B";
        a[23:16] = "B";
        settle();
        set_config(b32c_pkg::DIR_ENCODE, a);
        send_item(8'h00, 1'b1);
        settle();
        write_reg(b32c_pkg::REG_DIRECTION, b32c_pkg::CFG_DATA_W'(b32c_pkg::DIR_DECODE));
        send_item("B", 1'b0);
        send_item("B", 1'b1);
    endtask

    task automatic test_direction_clear();
        settle();
        set_config(b32c_pkg::DIR_ENCODE, std_alpha);
        send_item(8'hFF, 1'b0);
        settle();
        write_reg(b32c_pkg::REG_DIRECTION, b32c_pkg::CFG_DATA_W'(b32c_pkg::DIR_ENCODE));
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_random_traffic();
        logic [255:0] alpha;
        logic         dir;
        int           sent;
        int           len;
        bit           close;
        bit           paused;
        paused = 1'b0;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            dir = p[0] ? b32c_pkg::DIR_DECODE : b32c_pkg::DIR_ENCODE;
            case (p / 2)
                0: alpha = std_alpha;
                1: alpha = random_alphabet(1'b1);
                2: alpha = '1;
                3: alpha = random_alphabet(1'b0);
                4: alpha = '0;
                default: alpha = hex_alpha;
            endcase
            settle();
            set_config(dir, alpha);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
                // the final message of a phase is sometimes left open
                close = !((sent + len >= PHASE_ITEMS) && ($urandom_range(0, 3) == 0));
                random_message(len, close);
                sent += len;
                if (p == 1 && sent >= PHASE_ITEMS / 2 && !paused)
                begin
                    settle();
                    paused = 1'b1;
                end
            end
        end
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(10, 80);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   take = 1'b1;
            RX_PATCHY: take = ($urandom_range(0, 1) == 1);
            default:   take = ($urandom_range(0, 4) == 0);
        endcase
        if (rx_low_run >= 7)
            take = 1'b1;
        rx_low_run = take ? 0 : rx_low_run + 1;
        res_if.ready <= take;
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got.value = res_if.out_value;
            got.valid = res_if.out_valid;
            got.error = res_if.out_error;
            got.last  = res_if.out_last;
            if (pending_out.size() == 0)
            begin
                $display("%0t: unexpected item value=%02h valid=%b error=%b last=%b",
                         $time, got.value, got.valid, got.error, got.last);
                fails++;
            end
            else
            begin
                want = pending_out.pop_front();
                if (got.value !== want.value || got.valid !== want.valid ||
                    got.error !== want.error || got.last !== want.last)
                begin
                    $display("%0t: mismatch expected value=%02h valid=%b error=%b last=%b",
                             $time, want.value, want.valid, want.error, want.last);
                    $display("%0t:          actual   value=%02h valid=%b error=%b last=%b",
                             $time, got.value, got.valid, got.error, got.last);
                    fails++;
                end
            end
        end
    end

    // watchdog on cycles in which nothing moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || write_enable)
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        write_enable    = 1'b0;
        write_index     = '0;
        write_data      = '0;
        req_if.valid    = 1'b0;
        req_if.in_value = 8'h00;
        req_if.in_last  = 1'b0;
        burst_left      = 0;
        std_alpha       = alpha_from_text("ABCDEFGHIJKLMNOPQRSTUVWXYZ234567");
        hex_alpha       = alpha_from_text("0123456789ABCDEFGHIJKLMNOPQRSTUV");
        reset_model();
        wait (rst_n === 1'b1);
        @(posedge clk);
        test_encode_basics();
        test_decode_basics();
        test_alphabet_corners();
        test_direction_clear();
        test_random_traffic();
        settle();
        if (fails == 0 && pending_out.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
sv/b32c_pkg.sv
sv/b32c_if.sv
sv/b32c_cfg.sv
sv/b32c_step.sv
sv/b32c_outbuf.sv
sv/base32_codec_unit.sv
sim/tb_base32_codec_unit.sv
